// ----- hw/rtl/key_sorter_defines.svh -----
// Assertion macros for the key sorter.
`ifndef KEY_SORTER_DEFINES_SVH
`define KEY_SORTER_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define KS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define KS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/ks_pkg.sv -----
// Shared types and constants of the key sorter.
package ks_pkg;

  localparam int KS_CAPACITY = 32;
  localparam int KS_KEY_W    = 32;

  typedef struct packed {
    logic signed [KS_KEY_W-1:0] key;
    logic                       is_last;
  } ks_in_t;

  typedef struct packed {
    logic signed [KS_KEY_W-1:0] sorted_key;
    logic                       end_of_set;
    logic                       overflowed;
  } ks_out_t;

  typedef struct packed {
    logic load;
    logic drain;
  } ks_ctrl_t;

endpackage

// ----- hw/rtl/key_sorter.sv -----
// Top level of the key sorter: a chain of insertion cells and the result register.
// Keys are taken one per cycle and inserted in ascending signed order into a chain
// of CAPACITY cells; each cell compares its key with the broadcast new key and
// either keeps it, takes the new key, or takes its left neighbor's key. Keys that
// arrive with the chain full are dropped and flag overflowed on the whole set. Once
// the key with is_last is transferred, draining_r is set; the chain then shifts
// toward cell 0 and emits one result per cycle (n results for n held keys, slower
// only when the output stalls); in_stall is high during that drain. The result
// register lets a new set start while the final result of the previous set still
// waits.
module key_sorter #(
  parameter int CAPACITY = ks_pkg::KS_CAPACITY
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  ks_pkg::ks_in_t  in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output ks_pkg::ks_out_t out_data
);
  import ks_pkg::*;
  `include "key_sorter_defines.svh"

  logic signed [KS_KEY_W-1:0] key_w [CAPACITY];
  logic [CAPACITY-1:0]        valid_w;
  logic [CAPACITY-1:0]        gt_w;

  ks_ctrl_t ctrl;
  logic     in_xfer, full, step;

  logic    draining_r, draining_nxt;
  logic    ovf_r, ovf_nxt;
  logic    out_valid_r, out_valid_nxt;
  ks_out_t out_data_r, out_data_nxt;

  assign full     = valid_w[CAPACITY-1];
  assign in_stall = draining_r;
  assign in_xfer  = in_valid && !in_stall;
  assign step     = draining_r && (!out_valid_r || !out_stall);

  assign ctrl.load  = in_xfer && !full;
  assign ctrl.drain = step;

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [KS_KEY_W-1:0] lk, rk;
      logic                       lv, lg, rv;
      if (i == 0) begin : g_first
        assign lk = in_data.key;
        assign lv = 1'b0;
        assign lg = 1'b0;
      end else begin : g_mid
        assign lk = key_w[i-1];
        assign lv = valid_w[i-1];
        assign lg = gt_w[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
        assign rk = '0;
        assign rv = 1'b0;
      end else begin : g_inner
        assign rk = key_w[i+1];
        assign rv = valid_w[i+1];
      end
      ks_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .new_key    (in_data.key),
        .left_key   (lk),
        .left_valid (lv),
        .left_gt    (lg),
        .right_key  (rk),
        .right_valid(rv),
        .key        (key_w[i]),
        .valid      (valid_w[i]),
        .gt         (gt_w[i])
      );
    end
  endgenerate

  always_comb begin
    draining_nxt  = draining_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (in_xfer) begin
      if (full) begin
        ovf_nxt = 1'b1;
      end
      if (in_data.is_last) begin
        draining_nxt = 1'b1;
      end
    end
    if (step) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt.sorted_key = key_w[0];
      out_data_nxt.end_of_set = !valid_w[1];
      out_data_nxt.overflowed = ovf_r;
      if (!valid_w[1]) begin
        draining_nxt = 1'b0;
        ovf_nxt      = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      draining_r  <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      draining_r  <= draining_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `KS_ASSERT_IMP(a_drain_has_key, draining_r, valid_w[0], "drain with empty head cell")
  `KS_ASSERT_IMP(a_valid_packed, 1'b1, ((valid_w + 1'b1) & valid_w) == '0,
                 "hole in cell chain")
  `KS_ASSERT_NXT(a_last_starts_drain, in_xfer && in_data.is_last, draining_r && valid_w[0],
                 "flagged key did not start drain")
  `KS_ASSERT_NXT(a_end_stops_drain, step && !valid_w[1], !draining_r && !ovf_r,
                 "drain ran past end of set")

endmodule

// ----- hw/rtl/ks_cell.sv -----
// One cell of the sorting chain: holds one key and its valid bit.
module ks_cell (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ks_pkg::ks_ctrl_t                   ctrl,
  input  logic signed [ks_pkg::KS_KEY_W-1:0] new_key,
  input  logic signed [ks_pkg::KS_KEY_W-1:0] left_key,
  input  logic                               left_valid,
  input  logic                               left_gt,
  input  logic signed [ks_pkg::KS_KEY_W-1:0] right_key,
  input  logic                               right_valid,
  output logic signed [ks_pkg::KS_KEY_W-1:0] key,
  output logic                               valid,
  output logic                               gt
);
  import ks_pkg::*;

  logic signed [KS_KEY_W-1:0] key_r, key_nxt;
  logic                       valid_r, valid_nxt;

  // Empty cells act as +infinity so the new key lands before every empty cell.
  assign gt = !valid_r || (key_r > new_key);

  always_comb begin
    key_nxt   = key_r;
    valid_nxt = valid_r;
    if (ctrl.load) begin
      if (gt) begin
        if (left_gt) begin
          key_nxt   = left_key;
          valid_nxt = left_valid;
        end else begin
          key_nxt   = new_key;
          valid_nxt = 1'b1;
        end
      end
    end else if (ctrl.drain) begin
      key_nxt   = right_key;
      valid_nxt = right_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    key_r <= key_nxt;
  end

  assign key   = key_r;
  assign valid = valid_r;

endmodule

// ----- test/tb.sv -----
// Testbench for key_sorter: table-driven and random key sets checked against a sorting predictor.
`timescale 1ns / 100ps

module tb;
  import ks_pkg::*;

  localparam int RAND_ITEMS  = 470;
  localparam int HOLD_CYCLES = 300;
  localparam int DIR_N       = 23;

  localparam logic signed [KS_KEY_W-1:0] KEY_MIN = {1'b1, {(KS_KEY_W-1){1'b0}}};
  localparam logic signed [KS_KEY_W-1:0] KEY_MAX = {1'b0, {(KS_KEY_W-1){1'b1}}};
  localparam ks_out_t NO_WANT = '0;

  typedef struct packed {
    logic signed [KS_KEY_W-1:0] key;
    logic                       last;
    logic                       typed;
    ks_out_t                    want;
  } key_row_t;

  // key, is_last, typed expectation, {sorted_key, end_of_set, overflowed}
  localparam key_row_t DIR_TAB [DIR_N] = '{
    {32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, 1'b1, 1'b0},
    {KEY_MAX,       1'b1, 1'b1, KEY_MAX,       1'b1, 1'b0},
    {KEY_MIN,       1'b1, 1'b1, KEY_MIN,       1'b1, 1'b0},
    {32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0},
    {32'h0000_0001, 1'b1, 1'b1, 32'h0000_0001, 1'b1, 1'b0},
    {32'h5555_5555, 1'b1, 1'b1, 32'h5555_5555, 1'b1, 1'b0},
    {32'hAAAA_AAAA, 1'b1, 1'b1, 32'hAAAA_AAAA, 1'b1, 1'b0},
    {32'h0000_0005, 1'b0, 1'b0, NO_WANT},
    {32'hFFFF_FFFB, 1'b0, 1'b0, NO_WANT},
    {32'h0000_0005, 1'b0, 1'b0, NO_WANT},
    {KEY_MIN,       1'b0, 1'b0, NO_WANT},
    {KEY_MAX,       1'b1, 1'b0, NO_WANT},
    {KEY_MIN,       1'b0, 1'b0, NO_WANT},
    {KEY_MIN,       1'b0, 1'b0, NO_WANT},
    {KEY_MIN,       1'b0, 1'b0, NO_WANT},
    {KEY_MIN,       1'b1, 1'b0, NO_WANT},
    {32'h0000_0003, 1'b0, 1'b0, NO_WANT},
    {32'h0000_0002, 1'b0, 1'b0, NO_WANT},
    {32'h0000_0001, 1'b0, 1'b0, NO_WANT},
    {32'h0000_0000, 1'b1, 1'b0, NO_WANT},
    {32'hFFFF_FFFE, 1'b0, 1'b0, NO_WANT},
    {32'hFFFF_FFFF, 1'b0, 1'b0, NO_WANT},
    {32'h0000_0001, 1'b1, 1'b0, NO_WANT}
  };

  logic    clk = 1'b0;
  logic    rst_n;
  logic    in_valid;
  logic    in_stall;
  ks_in_t  in_data;
  logic    out_valid;
  logic    out_stall;
  ks_out_t out_data;

  logic signed [KS_KEY_W-1:0] held_keys [$];
  bit      held_ovf;
  ks_out_t sorted_q [$];

  bit tx_calm;
  bit rx_calm;
  bit hold_off;
  int bad_count;
  int results_seen;
  int sets_done;
  int ovf_sets;
  int keys_sent;
  int holds_done;

  key_sorter uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int gap_draw();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic int tx_gap();
    if (tx_calm || $urandom_range(0, 9) < 6) return 0;
    return gap_draw();
  endfunction

  function automatic logic signed [KS_KEY_W-1:0] rand_key();
    int pick;
    int near;
    pick = $urandom_range(0, 15);
    near = $urandom_range(0, 8);
    if (pick == 0) return KEY_MIN;
    if (pick == 1) return KEY_MAX;
    if (pick < 6) return near - 4;
    return $urandom;
  endfunction

  // Takes one key into the set; on the last key sorts it and queues results if emit is set.
  function automatic void absorb_key(input ks_in_t item, input bit emit);
    logic signed [KS_KEY_W-1:0] run [$];
    logic signed [KS_KEY_W-1:0] v;
    ks_out_t r;
    int j;
    if (held_keys.size() < KS_CAPACITY) held_keys.push_back(item.key);
    else held_ovf = 1'b1;
    if (!item.is_last) return;
    run = held_keys;
    for (int i = 1; i < run.size(); i++) begin
      v = run[i];
      j = i;
      while (j > 0 && run[j-1] > v) begin
        run[j] = run[j-1];
        j--;
      end
      run[j] = v;
    end
    for (int k = 0; k < run.size(); k++) begin
      r.sorted_key = run[k];
      r.end_of_set = (k == run.size() - 1);
      r.overflowed = held_ovf;
      if (emit) sorted_q.push_back(r);
    end
    sets_done++;
    if (held_ovf) ovf_sets++;
    held_keys.delete();
    held_ovf = 1'b0;
  endfunction

  task automatic note_bad(input string msg);
    if (bad_count < 10) $display("MISMATCH at %0t: %s", $time, msg);
    bad_count++;
  endtask

  task automatic push_key(input ks_in_t item, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    keys_sent++;
  endtask

  always @(posedge clk) begin : result_check
    ks_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (sorted_q.size() == 0) begin
        note_bad($sformatf("unexpected result key=%0d eos=%b ovf=%b",
                           out_data.sorted_key, out_data.end_of_set, out_data.overflowed));
      end else begin
        want = sorted_q.pop_front();
        if (out_data.sorted_key !== want.sorted_key || out_data.end_of_set !== want.end_of_set ||
            out_data.overflowed !== want.overflowed) begin
          note_bad($sformatf("result %0d: expected key=%0d eos=%b ovf=%b, got key=%0d eos=%b ovf=%b",
                             results_seen, want.sorted_key, want.end_of_set, want.overflowed,
                             out_data.sorted_key, out_data.end_of_set, out_data.overflowed));
        end
      end
    end
  end

  initial begin : stall_gen
    int run;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_off = 1'b0;
        holds_done++;
      end else if (!rx_calm && $urandom_range(0, 3) == 0) begin
        run = gap_draw();
        out_stall <= 1'b1;
        repeat (run) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stim
    ks_in_t item;
    int     rand_items;
    int     set_idx;
    int     len;
    int     r;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    tx_calm   = 1'b0;
    rx_calm   = 1'b0;
    hold_off  = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_N; i++) begin
      item.key     = DIR_TAB[i].key;
      item.is_last = DIR_TAB[i].last;
      push_key(item, tx_gap());
      absorb_key(item, !DIR_TAB[i].typed);
      if (DIR_TAB[i].typed) sorted_q.push_back(DIR_TAB[i].want);
    end

    rand_items = 0;
    set_idx    = 0;
    while (rand_items < RAND_ITEMS) begin
      if (set_idx == 0) len = KS_CAPACITY;
      else if (set_idx == 1) len = KS_CAPACITY + 1;
      else if (set_idx == 2) len = KS_CAPACITY + 8;
      else begin
        r = $urandom_range(0, 99);
        if (r < 65) len = $urandom_range(1, 6);
        else if (r < 90) len = $urandom_range(7, KS_CAPACITY - 1);
        else len = $urandom_range(KS_CAPACITY, KS_CAPACITY + 8);
      end
      rx_calm = (set_idx % 6 == 4);
      tx_calm = rx_calm || set_idx == 1 || set_idx == 21;
      // drain pause: sender waits until all results of earlier sets are out
      if (set_idx % 7 == 5) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (sorted_q.size() != 0) @(posedge clk);
      end
      for (int k = 0; k < len; k++) begin
        item.key     = rand_key();
        item.is_last = (k == len - 1);
        push_key(item, tx_gap());
        absorb_key(item, 1'b1);
        rand_items++;
      end
      if (set_idx == 0 || set_idx == 20) hold_off = 1'b1;
      set_idx++;
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (sorted_q.size() != 0) @(posedge clk);
    repeat (2 * KS_CAPACITY + 8) @(posedge clk);

    $display("Sorted %0d sets from %0d keys (%0d over capacity), %0d results checked.",
             sets_done, keys_sent, ovf_sets, results_seen);
    $display("Receiver held off %0d times for %0d cycles, with random gaps and drain pauses.",
             holds_done, HOLD_CYCLES);
    if (sorted_q.size() != 0) note_bad($sformatf("%0d results never arrived", sorted_q.size()));
    if (bad_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches in total", bad_count);
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #(2_000_000);
    $display("Timeout with %0d results outstanding", sorted_q.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/ks_pkg.sv
hw/rtl/ks_cell.sv
hw/rtl/key_sorter.sv
test/tb.sv
